// ===== hdl/hbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// hbrm_pkg
// Shared constants, codes and controller/datapath interface types for the
// held buffer ring manager.
// ----------------------------------------------------------------------------
`default_nettype none

package hbrm_pkg;

    localparam int SLOTS     = 16;
    localparam int HOLD_BITS = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int POS_W     = SLOT_W + 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int TOTAL_W   = 16;
    localparam int LEN_W     = 16;
    localparam int NEED_W    = 8;
    localparam int OP_W      = 3;
    localparam int CMP_W     = (POS_W > NEED_W) ? POS_W : NEED_W;

    localparam int S_TDATA_W = 32;
    localparam int M_FIELD_W = 1 + POS_W + 1 + SLOT_W + POS_W + TOTAL_W + POS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [HOLD_BITS-1:0] HOLD_MAX  = {HOLD_BITS{1'b1}};
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_REQUEST = 3'd1,
        OP_AVAIL   = 3'd2,
        OP_NEXT    = 3'd3,
        OP_RELEASE = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_LOOKUP  = 3'd6,
        OP_NOP     = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        RSEL_REQ,
        RSEL_HANDLE,
        RSEL_NEXT,
        RSEL_OLDEST
    } ring_sel_t;

    typedef enum logic [1:0] {
        HOUT_HANDLE,
        HOUT_REQ,
        HOUT_NEXT
    } hout_sel_t;

    typedef struct packed {
        logic      load_in;
        ring_sel_t ring_sel;
        logic      push_commit;
        logic      hold_inc;
        logic      hold_dec;
        logic      hold_clr;
        logic      total_inc;
        logic      total_dec;
        logic      free_ring;
        logic      req_adv;
        logic      req_to_tail;
        logic      set_hout;
        hout_sel_t hout_sel;
        logic      set_houtv;
        logic      set_ok;
        logic      ok_avail;
        logic      set_sid;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    live;
        logic    push_ok;
        logic    req_ok;
        logic    nx_is_tail;
        logic    ring_empty;
        logic    reclaim_stop;
        logic    holds_zero;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/hbrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbrm_ctrl
// Sequencer that steps each request through ring reads, hold updates, the
// reclaim walk and the clear walk, and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module hbrm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire hbrm_pkg::status_t stat,
    output hbrm_pkg::cmd_t        cmd
);
    import hbrm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_FETCH,
        S_HFETCH,
        S_APPLY,
        S_RC_SEL,
        S_CL_SEL,
        S_CL_FETCH,
        S_CL_APPLY,
        S_DONE
    } state_t;

    state_t    state_reg, state_next;
    ring_sel_t sel_reg, sel_next;
    logic      phase_reg, phase_next;
    logic      m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        cmd.ring_sel = sel_reg;
        state_next   = state_reg;
        sel_next     = sel_reg;
        phase_next   = phase_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.op)
                    OP_PUSH: begin
                        cmd.push_commit = stat.push_ok;
                        state_next      = S_DONE;
                    end
                    OP_REQUEST: begin
                        if (stat.req_ok) begin
                            sel_next   = RSEL_REQ;
                            state_next = S_FETCH;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_AVAIL, OP_LOOKUP: begin
                        cmd.set_hout = 1'b1;
                        cmd.hout_sel = HOUT_HANDLE;
                        if (stat.live) begin
                            sel_next   = RSEL_HANDLE;
                            state_next = S_FETCH;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_NEXT: begin
                        cmd.set_hout = 1'b1;
                        cmd.hout_sel = HOUT_HANDLE;
                        if (stat.live) begin
                            cmd.set_houtv = 1'b1;
                            sel_next      = RSEL_HANDLE;
                            state_next    = S_FETCH;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_RELEASE: begin
                        if (stat.live) begin
                            sel_next   = RSEL_HANDLE;
                            state_next = S_FETCH;
                        end else begin
                            phase_next = 1'b1;
                            state_next = S_RC_SEL;
                        end
                    end
                    OP_CLEAR: begin
                        state_next = S_CL_SEL;
                    end
                    OP_NOP: begin
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FETCH: begin
                state_next = S_HFETCH;
            end
            S_HFETCH: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                unique case (stat.op)
                    OP_REQUEST: begin
                        cmd.hold_inc  = 1'b1;
                        cmd.total_inc = 1'b1;
                        cmd.set_hout  = 1'b1;
                        cmd.hout_sel  = HOUT_REQ;
                        cmd.set_houtv = 1'b1;
                        cmd.set_sid   = 1'b1;
                        cmd.set_ok    = 1'b1;
                        cmd.req_adv   = 1'b1;
                        state_next    = S_DONE;
                    end
                    OP_AVAIL: begin
                        cmd.set_houtv = 1'b1;
                        cmd.set_sid   = 1'b1;
                        cmd.ok_avail  = 1'b1;
                        state_next    = S_DONE;
                    end
                    OP_LOOKUP: begin
                        cmd.set_houtv = 1'b1;
                        cmd.set_sid   = 1'b1;
                        cmd.set_ok    = 1'b1;
                        state_next    = S_DONE;
                    end
                    OP_NEXT: begin
                        if (stat.nx_is_tail) begin
                            cmd.set_sid = 1'b1;
                            state_next  = S_DONE;
                        end else if (!phase_reg) begin
                            cmd.hold_dec = 1'b1;
                            sel_next     = RSEL_NEXT;
                            phase_next   = 1'b1;
                            state_next   = S_FETCH;
                        end else begin
                            cmd.hold_inc = 1'b1;
                            cmd.set_hout = 1'b1;
                            cmd.hout_sel = HOUT_NEXT;
                            cmd.set_sid  = 1'b1;
                            cmd.set_ok   = 1'b1;
                            state_next   = S_DONE;
                        end
                    end
                    OP_RELEASE: begin
                        if (!phase_reg) begin
                            cmd.hold_dec  = 1'b1;
                            cmd.total_dec = 1'b1;
                            cmd.set_sid   = 1'b1;
                            cmd.set_ok    = 1'b1;
                            phase_next    = 1'b1;
                            state_next    = S_RC_SEL;
                        end else if (stat.holds_zero) begin
                            cmd.free_ring = 1'b1;
                            state_next    = S_RC_SEL;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RC_SEL: begin
                if (stat.reclaim_stop) begin
                    state_next = S_DONE;
                end else begin
                    sel_next   = RSEL_OLDEST;
                    state_next = S_FETCH;
                end
            end
            S_CL_SEL: begin
                if (stat.ring_empty) begin
                    cmd.req_to_tail = 1'b1;
                    cmd.set_ok      = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    sel_next   = RSEL_OLDEST;
                    state_next = S_CL_FETCH;
                end
            end
            S_CL_FETCH: begin
                state_next = S_CL_APPLY;
            end
            S_CL_APPLY: begin
                cmd.hold_clr  = 1'b1;
                cmd.free_ring = 1'b1;
                state_next    = S_CL_SEL;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= RSEL_REQ;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/hbrm_dp.sv =====
// ----------------------------------------------------------------------------
// hbrm_dp
// Ring positions, free stack, order ring, per-slot hold counts, counters and
// the request and result registers of the held buffer ring manager.
// ----------------------------------------------------------------------------
`default_nettype none

module hbrm_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire hbrm_pkg::cmd_t                    cmd,
    output hbrm_pkg::status_t                      stat,
    input  wire logic [hbrm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [hbrm_pkg::OP_W-1:0]         s_tuser,
    output logic      [hbrm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hbrm_pkg::LEN_W-1:0]        cfg_data
);
    import hbrm_pkg::*;

    logic [LEN_W-1:0]     item_len_reg;

    opcode_t              op_reg;
    logic [POS_W-1:0]     h_reg;
    logic                 hv_reg;
    logic [NEED_W-1:0]    need_reg;
    logic [LEN_W-1:0]     blen_reg;

    logic [POS_W-1:0]     oldest_reg, req_reg, tail_reg;
    logic [CNT_W-1:0]     fc_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [POS_W-1:0]     peak_reg;

    logic [SLOT_W-1:0]    order_ring_reg [SLOTS];
    logic [SLOT_W-1:0]    free_stack_reg [SLOTS];
    logic [HOLD_BITS-1:0] holds_reg      [SLOTS];
    logic [SLOT_W-1:0]    ring_rd_reg;
    logic [SLOT_W-1:0]    fs_rd_reg;
    logic [HOLD_BITS-1:0] holds_rd_reg;

    logic                 res_ok_reg;
    logic [POS_W-1:0]     res_hout_reg;
    logic                 res_houtv_reg;
    logic [SLOT_W-1:0]    res_sid_reg;

    logic [M_TDATA_W-1:0] m_data_reg;

    logic [POS_W-1:0]     nx;
    logic [POS_W-1:0]     tail_inc;
    logic [POS_W-1:0]     occ;
    logic [POS_W-1:0]     occ_after_push;
    logic [POS_W-1:0]     h_off;
    logic [POS_W-1:0]     req_ahead;
    logic [POS_W-1:0]     h_ahead;
    logic [NEED_W-1:0]    need_eff;
    logic                 avail_ok;
    logic [POS_W-1:0]     ring_addr;
    logic [CNT_W-1:0]     fc_dec;
    logic                 fs_room;

    assign cfg_ready = 1'b1;

    assign nx             = h_reg + POS_W'(1);
    assign tail_inc       = tail_reg + POS_W'(1);
    assign occ            = tail_reg - oldest_reg;
    assign occ_after_push = tail_inc - oldest_reg;
    assign h_off          = h_reg - oldest_reg;
    assign req_ahead      = tail_reg - req_reg;
    assign h_ahead        = tail_reg - h_reg;
    assign need_eff       = (need_reg == '0) ? NEED_W'(1) : need_reg;
    assign avail_ok       = CMP_W'(h_ahead) >= CMP_W'(need_eff);
    assign fc_dec         = fc_reg - CNT_W'(1);
    assign fs_room        = fc_reg < CNT_W'(SLOTS);

    always_comb begin
        unique case (cmd.ring_sel)
            RSEL_REQ:    ring_addr = req_reg;
            RSEL_HANDLE: ring_addr = h_reg;
            RSEL_NEXT:   ring_addr = nx;
            RSEL_OLDEST: ring_addr = oldest_reg;
            default:     ring_addr = req_reg;
        endcase
    end

    always_comb begin
        stat.op           = op_reg;
        stat.live         = hv_reg && (h_off < occ);
        stat.push_ok      = (blen_reg == item_len_reg) && (fc_reg != '0);
        stat.req_ok       = (req_reg != tail_reg) && (CMP_W'(req_ahead) >= CMP_W'(need_eff));
        stat.nx_is_tail   = (nx == tail_reg);
        stat.ring_empty   = (oldest_reg == tail_reg);
        stat.reclaim_stop = (oldest_reg == tail_reg) || (oldest_reg == req_reg);
        stat.holds_zero   = (holds_rd_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_len_reg <= LEN_W'(1024);
        end else if (cfg_valid) begin
            item_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= opcode_t'(s_tuser);
            h_reg    <= s_tdata[POS_W-1:0];
            hv_reg   <= s_tdata[POS_W];
            need_reg <= s_tdata[POS_W+1 +: NEED_W];
            blen_reg <= s_tdata[POS_W+1+NEED_W +: LEN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_commit) begin
            order_ring_reg[tail_reg[SLOT_W-1:0]] <= fs_rd_reg;
        end
        ring_rd_reg  <= order_ring_reg[ring_addr[SLOT_W-1:0]];
        fs_rd_reg    <= free_stack_reg[fc_dec[SLOT_W-1:0]];
        holds_rd_reg <= holds_reg[ring_rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                free_stack_reg[i] <= SLOT_W'(i);
            end
        end else if (cmd.free_ring && fs_room) begin
            free_stack_reg[fc_reg[SLOT_W-1:0]] <= ring_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                holds_reg[i] <= '0;
            end
        end else if (cmd.push_commit) begin
            holds_reg[fs_rd_reg] <= '0;
        end else if (cmd.hold_clr) begin
            holds_reg[ring_rd_reg] <= '0;
        end else if (cmd.hold_inc) begin
            if (holds_rd_reg != HOLD_MAX) begin
                holds_reg[ring_rd_reg] <= holds_rd_reg + HOLD_BITS'(1);
            end
        end else if (cmd.hold_dec) begin
            if (holds_rd_reg != '0) begin
                holds_reg[ring_rd_reg] <= holds_rd_reg - HOLD_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            req_reg    <= '0;
            tail_reg   <= '0;
            fc_reg     <= CNT_W'(SLOTS);
            total_reg  <= '0;
            peak_reg   <= '0;
        end else begin
            if (cmd.push_commit) begin
                tail_reg <= tail_inc;
                fc_reg   <= fc_dec;
                if (occ_after_push > peak_reg) begin
                    peak_reg <= occ_after_push;
                end
            end
            if (cmd.free_ring) begin
                oldest_reg <= oldest_reg + POS_W'(1);
                if (fs_room) begin
                    fc_reg <= fc_reg + CNT_W'(1);
                end
            end
            if (cmd.req_adv) begin
                req_reg <= req_reg + POS_W'(1);
            end else if (cmd.req_to_tail) begin
                req_reg <= tail_reg;
            end
            if (cmd.total_inc && total_reg != TOTAL_MAX) begin
                total_reg <= total_reg + TOTAL_W'(1);
            end else if (cmd.total_dec && total_reg != '0) begin
                total_reg <= total_reg - TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            res_ok_reg    <= 1'b0;
            res_hout_reg  <= '0;
            res_houtv_reg <= 1'b0;
            res_sid_reg   <= '0;
        end else begin
            if (cmd.push_commit) begin
                res_ok_reg  <= 1'b1;
                res_sid_reg <= fs_rd_reg;
            end
            if (cmd.set_ok) begin
                res_ok_reg <= 1'b1;
            end else if (cmd.ok_avail) begin
                res_ok_reg <= avail_ok;
            end
            if (cmd.set_houtv) begin
                res_houtv_reg <= 1'b1;
            end
            if (cmd.set_sid) begin
                res_sid_reg <= ring_rd_reg;
            end
            if (cmd.set_hout) begin
                unique case (cmd.hout_sel)
                    HOUT_HANDLE: res_hout_reg <= h_reg;
                    HOUT_REQ:    res_hout_reg <= req_reg;
                    HOUT_NEXT:   res_hout_reg <= nx;
                    default:     res_hout_reg <= h_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= M_TDATA_W'({peak_reg, total_reg, occ, res_sid_reg,
                                      res_houtv_reg, res_hout_reg, res_ok_reg});
        end
    end

    assign m_tdata = m_data_reg;

endmodule

`default_nettype wire

// ===== hdl/held_buffer_ring_manager_core.sv =====
// A release may walk the ring from its oldest entry, reclaiming entries that are no
// longer held, and a clear walks and frees every ring entry.
// Throughput: one request at a time, the next taken in the cycle after the result loads,
// which waits only while an older result is unaccepted. Reset: synchronous aresetn.
// ----------------------------------------------------------------------------
// held_buffer_ring_manager_core
// Reference-counted buffer pool with a free stack, an ordered ring of filled
// slots and per-slot hold counts, split into a sequencer and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module held_buffer_ring_manager_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // handle[4:0], handle_valid[5], need_count[13:6], byte_length[29:14]
    input  wire logic [hbrm_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[2:0]
    input  wire logic [hbrm_pkg::OP_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], handle_out[5:1], handle_out_valid[6], slot_id[10:7],
    // occupied[15:11], total_holds[31:16], high_water[36:32]
    output logic      [hbrm_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hbrm_pkg::LEN_W-1:0]     cfg_data
);
    import hbrm_pkg::*;

    cmd_t    cmd;
    status_t stat;

    hbrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hbrm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== hdl/hbrm_checker.sv =====
// ----------------------------------------------------------------------------
// hbrm_checker
// Port-level checks on the held buffer ring manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hbrm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hbrm_pkg::M_TDATA_W-1:0] m_tdata
);
    import hbrm_pkg::*;

    logic [POS_W-1:0] occ_w;
    logic [POS_W-1:0] hw_w;

    assign occ_w = m_tdata[2+POS_W+SLOT_W +: POS_W];
    assign hw_w  = m_tdata[2+2*POS_W+SLOT_W+TOTAL_W +: POS_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second request taken while one is in progress.");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ_w <= POS_W'(SLOTS))
        else $error("Occupancy exceeds the number of slots.");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hw_w >= occ_w)
        else $error("High water is below current occupancy.");

endmodule

bind held_buffer_ring_manager_core hbrm_checker u_hbrm_checker (.*);

`default_nettype wire
